// ----- sv/ebalu_pkg.sv -----
// shared types, command codes and constants for the eight-bit alu
`default_nettype none
package ebalu_pkg;

  localparam logic [4:0] CMD_ADD   = 5'd0;
  localparam logic [4:0] CMD_ADC   = 5'd1;
  localparam logic [4:0] CMD_SUB   = 5'd2;
  localparam logic [4:0] CMD_SBC   = 5'd3;
  localparam logic [4:0] CMD_AND   = 5'd4;
  localparam logic [4:0] CMD_XOR   = 5'd5;
  localparam logic [4:0] CMD_OR    = 5'd6;
  localparam logic [4:0] CMD_CP    = 5'd7;
  localparam logic [4:0] CMD_INC   = 5'd8;
  localparam logic [4:0] CMD_DEC   = 5'd9;
  localparam logic [4:0] CMD_RLC   = 5'd10;
  localparam logic [4:0] CMD_RL    = 5'd11;
  localparam logic [4:0] CMD_RRC   = 5'd12;
  localparam logic [4:0] CMD_RR    = 5'd13;
  localparam logic [4:0] CMD_SLA   = 5'd14;
  localparam logic [4:0] CMD_SRA   = 5'd15;
  localparam logic [4:0] CMD_SWAP  = 5'd16;
  localparam logic [4:0] CMD_SRL   = 5'd17;
  localparam logic [4:0] CMD_BIT   = 5'd18;
  localparam logic [4:0] CMD_RES   = 5'd19;
  localparam logic [4:0] CMD_SET   = 5'd20;
  localparam logic [4:0] CMD_DAA   = 5'd21;
  localparam logic [4:0] CMD_CPL   = 5'd22;
  localparam logic [4:0] CMD_SCF   = 5'd23;
  localparam logic [4:0] CMD_CCF   = 5'd24;
  localparam logic [4:0] CMD_RLCA  = 5'd25;
  localparam logic [4:0] CMD_RLA   = 5'd26;
  localparam logic [4:0] CMD_RRCA  = 5'd27;
  localparam logic [4:0] CMD_RRA   = 5'd28;
  localparam logic [4:0] CMD_ADD16 = 5'd29;

  localparam logic [7:0] DAA_LIMIT_HI = 8'h99;
  localparam logic [3:0] DAA_LIMIT_LO = 4'h9;
  localparam logic [7:0] DAA_FIX_HI   = 8'h60;
  localparam logic [7:0] DAA_FIX_LO   = 8'h06;

  typedef struct packed {
    logic [4:0]  command;
    logic [7:0]  operand_a;
    logic [7:0]  operand_b;
    logic [2:0]  bit_index;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic        zero;
    logic        subtract;
    logic        hc_flag;
    logic        carry;
  } ebalu_in_t;

  typedef struct packed {
    logic [7:0]  result_byte;
    logic [15:0] result_word;
    logic        writes_back;
    logic        zero;
    logic        subtract;
    logic        hc_flag;
    logic        carry;
  } ebalu_out_t;

endpackage
`default_nettype wire

// ----- sv/ebalu_core.sv -----
// combinational datapath: one command, operands and flags in, result and flags out
`default_nettype none
module ebalu_core
  import ebalu_pkg::*;
(
  input  ebalu_in_t  op_i,
  output ebalu_out_t res_o
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        ci;
  logic [8:0]  add9;
  logic [4:0]  add_lo;
  logic [8:0]  sub9;
  logic [4:0]  sub_lo;
  logic [16:0] add17;
  logic [12:0] add13;
  logic [7:0]  bit_mask;
  logic [7:0]  daa_adj;

  assign a  = op_i.operand_a;
  assign b  = op_i.operand_b;
  assign ci = ((op_i.command == CMD_ADC) || (op_i.command == CMD_SBC)) ? op_i.carry : 1'b0;

  assign add9   = {1'b0, a} + {1'b0, b} + {8'd0, ci};
  assign add_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
  assign sub9   = {1'b0, a} - {1'b0, b} - {8'd0, ci};
  assign sub_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};
  assign add17  = {1'b0, op_i.word_a} + {1'b0, op_i.word_b};
  assign add13  = {1'b0, op_i.word_a[11:0]} + {1'b0, op_i.word_b[11:0]};
  assign bit_mask = 8'd1 << op_i.bit_index;

  always_comb begin
    res_o             = '0;
    res_o.result_byte = a;
    res_o.result_word = '0;
    res_o.writes_back = 1'b1;
    res_o.zero        = op_i.zero;
    res_o.subtract    = op_i.subtract;
    res_o.hc_flag     = op_i.hc_flag;
    res_o.carry       = op_i.carry;
    daa_adj           = '0;
    case (op_i.command)
      CMD_ADD, CMD_ADC: begin
        res_o.result_byte = add9[7:0];
        res_o.zero        = (add9[7:0] == 8'd0);
        res_o.subtract    = 1'b0;
        res_o.hc_flag     = add_lo[4];
        res_o.carry       = add9[8];
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        res_o.result_byte = sub9[7:0];
        res_o.zero        = (sub9[7:0] == 8'd0);
        res_o.subtract    = 1'b1;
        res_o.hc_flag     = sub_lo[4];
        res_o.carry       = sub9[8];
        res_o.writes_back = (op_i.command != CMD_CP);
      end
      CMD_AND, CMD_XOR, CMD_OR: begin
        if (op_i.command == CMD_AND) begin
          res_o.result_byte = a & b;
        end else if (op_i.command == CMD_XOR) begin
          res_o.result_byte = a ^ b;
        end else begin
          res_o.result_byte = a | b;
        end
        res_o.zero     = (res_o.result_byte == 8'd0);
        res_o.subtract = 1'b0;
        res_o.hc_flag  = (op_i.command == CMD_AND);
        res_o.carry    = 1'b0;
      end
      CMD_INC: begin
        res_o.result_byte = a + 8'd1;
        res_o.zero        = (a == 8'hFF);
        res_o.subtract    = 1'b0;
        res_o.hc_flag     = (a[3:0] == 4'hF);
      end
      CMD_DEC: begin
        res_o.result_byte = a - 8'd1;
        res_o.zero        = (a == 8'd1);
        res_o.subtract    = 1'b1;
        res_o.hc_flag     = (a[3:0] == 4'h0);
      end
      CMD_RLC, CMD_RL, CMD_RRC, CMD_RR, CMD_SLA, CMD_SRA, CMD_SWAP, CMD_SRL,
      CMD_RLCA, CMD_RLA, CMD_RRCA, CMD_RRA: begin
        if (op_i.command inside {CMD_RLC, CMD_RLCA}) begin
          res_o.result_byte = {a[6:0], a[7]};
          res_o.carry       = a[7];
        end else if (op_i.command inside {CMD_RL, CMD_RLA}) begin
          res_o.result_byte = {a[6:0], op_i.carry};
          res_o.carry       = a[7];
        end else if (op_i.command inside {CMD_RRC, CMD_RRCA}) begin
          res_o.result_byte = {a[0], a[7:1]};
          res_o.carry       = a[0];
        end else if (op_i.command inside {CMD_RR, CMD_RRA}) begin
          res_o.result_byte = {op_i.carry, a[7:1]};
          res_o.carry       = a[0];
        end else if (op_i.command == CMD_SLA) begin
          res_o.result_byte = {a[6:0], 1'b0};
          res_o.carry       = a[7];
        end else if (op_i.command == CMD_SRA) begin
          res_o.result_byte = {a[7], a[7:1]};
          res_o.carry       = a[0];
        end else if (op_i.command == CMD_SWAP) begin
          res_o.result_byte = {a[3:0], a[7:4]};
          res_o.carry       = 1'b0;
        end else begin
          res_o.result_byte = {1'b0, a[7:1]};
          res_o.carry       = a[0];
        end
        // accumulator rotates always clear zero
        res_o.zero     = (op_i.command inside {CMD_RLCA, CMD_RLA, CMD_RRCA, CMD_RRA}) ?
                         1'b0 : (res_o.result_byte == 8'd0);
        res_o.subtract = 1'b0;
        res_o.hc_flag  = 1'b0;
      end
      CMD_BIT: begin
        res_o.zero        = ~|(a & bit_mask);
        res_o.subtract    = 1'b0;
        res_o.hc_flag     = 1'b1;
        res_o.writes_back = 1'b0;
      end
      CMD_RES: res_o.result_byte = a & ~bit_mask;
      CMD_SET: res_o.result_byte = a | bit_mask;
      CMD_DAA: begin
        if (op_i.subtract) begin
          daa_adj = (op_i.hc_flag ? DAA_FIX_LO : 8'd0) |
                    (op_i.carry ? DAA_FIX_HI : 8'd0);
          res_o.result_byte = a - daa_adj;
        end else begin
          daa_adj = ((op_i.hc_flag || (a[3:0] > DAA_LIMIT_LO)) ? DAA_FIX_LO : 8'd0) |
                    ((op_i.carry || (a > DAA_LIMIT_HI)) ? DAA_FIX_HI : 8'd0);
          res_o.result_byte = a + daa_adj;
          // carry can only be set after an addition
          res_o.carry       = op_i.carry || (a > DAA_LIMIT_HI);
        end
        res_o.zero    = (res_o.result_byte == 8'd0);
        res_o.hc_flag = 1'b0;
      end
      CMD_CPL: begin
        res_o.result_byte = ~a;
        res_o.subtract    = 1'b1;
        res_o.hc_flag     = 1'b1;
      end
      CMD_SCF, CMD_CCF: begin
        res_o.subtract    = 1'b0;
        res_o.hc_flag     = 1'b0;
        res_o.carry       = (op_i.command == CMD_SCF) ? 1'b1 : ~op_i.carry;
        res_o.writes_back = 1'b0;
      end
      CMD_ADD16: begin
        res_o.result_byte = 8'd0;
        res_o.result_word = add17[15:0];
        res_o.subtract    = 1'b0;
        res_o.hc_flag     = add13[12];
        res_o.carry       = add17[16];
      end
      default: res_o.writes_back = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/eight_bit_alu_with_flags.sv -----
// top level: registered eight-bit alu with flag handling and valid/stall channels
//
// usage
// - input channel: in_valid with the command, operands, bit index, two words
//   and four incoming flags; a transaction is taken at a rising edge with
//   in_valid high and in_stall low
// - result channel: out_valid with result byte, result word, write-back strobe
//   and four outgoing flags; taken at an edge with out_valid high and
//   out_stall low
// - two register stages: an input register, then the alu datapath, then a
//   result register; a transaction moves from the input register to the
//   result register once it is free (one per cycle while out_stall is low)
// - the rate is set only by the two stage registers; the datapath is one pass
//   of shallow adds, shifts and muxes
// - stall from the receiver holds the result register; the input register
//   keeps filling, and in_stall rises only once both stages hold transactions
// - synchronous active-low reset empties both stages; no configuration and
//   no state carried between transactions
`default_nettype none
module eight_bit_alu_with_flags
  import ebalu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [4:0]  in_command,
  input  wire logic [7:0]  in_operand_a,
  input  wire logic [7:0]  in_operand_b,
  input  wire logic [2:0]  in_bit_index,
  input  wire logic [15:0] in_word_a,
  input  wire logic [15:0] in_word_b,
  input  wire logic        in_zero_in,
  input  wire logic        in_subtract_in,
  input  wire logic        in_half_carry_in,
  input  wire logic        in_carry_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_result_byte,
  output logic [15:0]      out_result_word,
  output logic             out_writes_back,
  output logic             out_zero_out,
  output logic             out_subtract_out,
  output logic             out_half_carry_out,
  output logic             out_carry_out
);

  // stage 1: input register
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  ebalu_in_t  s1_data_r;
  ebalu_in_t  in_data;

  // stage 2: result register
  logic       out_valid_r;
  logic       out_valid_nxt;
  ebalu_out_t out_data_r;
  ebalu_out_t alu_res;

  logic       s2_ready;
  logic       s1_ready;

  assign in_data = '{command:    in_command,
                     operand_a:  in_operand_a,
                     operand_b:  in_operand_b,
                     bit_index:  in_bit_index,
                     word_a:     in_word_a,
                     word_b:     in_word_b,
                     zero:       in_zero_in,
                     subtract:   in_subtract_in,
                     hc_flag:    in_half_carry_in,
                     carry:      in_carry_in};

  // result register can load when empty or being drained this cycle
  assign s2_ready = !out_valid_r || !out_stall;
  // input register can load when empty or moving forward this cycle
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;

  assign s1_valid_nxt  = s1_ready ? in_valid : s1_valid_r;
  assign out_valid_nxt = s2_ready ? s1_valid_r : out_valid_r;

  ebalu_core u_core (
    .op_i  (s1_data_r),
    .res_o (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, loaded only when a transaction moves in
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (s2_ready && s1_valid_r) begin
      out_data_r <= alu_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_byte    = out_data_r.result_byte;
  assign out_result_word    = out_data_r.result_word;
  assign out_writes_back    = out_data_r.writes_back;
  assign out_zero_out       = out_data_r.zero;
  assign out_subtract_out   = out_data_r.subtract;
  assign out_half_carry_out = out_data_r.hc_flag;
  assign out_carry_out      = out_data_r.carry;

  // back-pressure only when both stages are full and the receiver stalls
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  // a staged transaction reaches the result register when not blocked
  a_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ready) |=> out_valid_r)
    else $error("staged transaction lost");

  // a held result keeps its valid while stalled
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");

  // a nonzero word only comes from the 16-bit add, which clears byte and subtract
  a_word_implies_add16: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.result_word != 16'd0)) |->
      ((out_data_r.result_byte == 8'd0) && !out_data_r.subtract && out_data_r.writes_back))
    else $error("word result with inconsistent byte or flags");

endmodule
`default_nettype wire

// ----- dv/alu_checker.sv -----
// checker for the eight-bit alu: predicts each transaction and compares results
`timescale 1ns / 1ps
module alu_checker
  import ebalu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [4:0]        in_command,
  input  logic [7:0]        in_operand_a,
  input  logic [7:0]        in_operand_b,
  input  logic [2:0]        in_bit_index,
  input  logic [15:0]       in_word_a,
  input  logic [15:0]       in_word_b,
  input  logic              in_zero_in,
  input  logic              in_subtract_in,
  input  logic              in_half_carry_in,
  input  logic              in_carry_in,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        out_result_byte,
  input  logic [15:0]       out_result_word,
  input  logic              out_writes_back,
  input  logic              out_zero_out,
  input  logic              out_subtract_out,
  input  logic              out_half_carry_out,
  input  logic              out_carry_out,
  output int unsigned       mismatch_count,
  output int unsigned       awaited_count
);

  typedef struct {
    ebalu_in_t  cause;
    ebalu_out_t outcome;
  } alu_expectation_t;

  alu_expectation_t pending_outcomes[$];

  initial begin
    mismatch_count = 0;
    awaited_count  = 0;
  end

  function automatic ebalu_out_t alu_predict(ebalu_in_t t);
    ebalu_out_t  o;
    logic        ci;
    logic        shifted;
    logic [8:0]  wide;
    logic [4:0]  nib;
    logic [16:0] sum_w;
    logic [12:0] sum_lo;
    logic [7:0]  adj;
    o.result_byte = t.operand_a;
    o.result_word = 16'h0000;
    o.writes_back = 1'b1;
    o.zero        = t.zero;
    o.subtract    = t.subtract;
    o.hc_flag     = t.hc_flag;
    o.carry       = t.carry;
    ci            = 1'b0;
    shifted       = 1'b0;
    adj           = 8'h00;
    case (t.command)
      CMD_ADD, CMD_ADC: begin
        if (t.command == CMD_ADC) ci = t.carry;
        wide = {1'b0, t.operand_a} + {1'b0, t.operand_b} + {8'b0, ci};
        nib  = {1'b0, t.operand_a[3:0]} + {1'b0, t.operand_b[3:0]} + {4'b0, ci};
        o.result_byte = wide[7:0];
        o.zero        = (wide[7:0] == 8'h00);
        o.subtract    = 1'b0;
        o.hc_flag     = nib[4];
        o.carry       = wide[8];
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        if (t.command == CMD_SBC) ci = t.carry;
        // borrow shows up as the extra top bit of the widened difference
        wide = {1'b0, t.operand_a} - {1'b0, t.operand_b} - {8'b0, ci};
        nib  = {1'b0, t.operand_a[3:0]} - {1'b0, t.operand_b[3:0]} - {4'b0, ci};
        o.result_byte = wide[7:0];
        o.zero        = (wide[7:0] == 8'h00);
        o.subtract    = 1'b1;
        o.hc_flag     = nib[4];
        o.carry       = wide[8];
        if (t.command == CMD_CP) o.writes_back = 1'b0;
      end
      CMD_AND: begin
        o.result_byte = t.operand_a & t.operand_b;
        o.zero        = (o.result_byte == 8'h00);
        o.subtract    = 1'b0;
        o.hc_flag     = 1'b1;
        o.carry       = 1'b0;
      end
      CMD_XOR, CMD_OR: begin
        o.result_byte = (t.command == CMD_XOR) ? (t.operand_a ^ t.operand_b)
                                               : (t.operand_a | t.operand_b);
        o.zero        = (o.result_byte == 8'h00);
        o.subtract    = 1'b0;
        o.hc_flag     = 1'b0;
        o.carry       = 1'b0;
      end
      CMD_INC: begin
        o.result_byte = t.operand_a + 8'h01;
        o.zero        = (o.result_byte == 8'h00);
        o.subtract    = 1'b0;
        o.hc_flag     = (t.operand_a[3:0] == 4'hF);
      end
      CMD_DEC: begin
        o.result_byte = t.operand_a - 8'h01;
        o.zero        = (o.result_byte == 8'h00);
        o.subtract    = 1'b1;
        o.hc_flag     = (t.operand_a[3:0] == 4'h0);
      end
      CMD_RLC, CMD_RLCA: begin
        o.result_byte = {t.operand_a[6:0], t.operand_a[7]};
        o.carry       = t.operand_a[7];
        shifted       = 1'b1;
      end
      CMD_RL, CMD_RLA: begin
        o.result_byte = {t.operand_a[6:0], t.carry};
        o.carry       = t.operand_a[7];
        shifted       = 1'b1;
      end
      CMD_RRC, CMD_RRCA: begin
        o.result_byte = {t.operand_a[0], t.operand_a[7:1]};
        o.carry       = t.operand_a[0];
        shifted       = 1'b1;
      end
      CMD_RR, CMD_RRA: begin
        o.result_byte = {t.carry, t.operand_a[7:1]};
        o.carry       = t.operand_a[0];
        shifted       = 1'b1;
      end
      CMD_SLA: begin
        o.result_byte = {t.operand_a[6:0], 1'b0};
        o.carry       = t.operand_a[7];
        shifted       = 1'b1;
      end
      CMD_SRA: begin
        o.result_byte = {t.operand_a[7], t.operand_a[7:1]};
        o.carry       = t.operand_a[0];
        shifted       = 1'b1;
      end
      CMD_SWAP: begin
        o.result_byte = {t.operand_a[3:0], t.operand_a[7:4]};
        o.carry       = 1'b0;
        shifted       = 1'b1;
      end
      CMD_SRL: begin
        o.result_byte = {1'b0, t.operand_a[7:1]};
        o.carry       = t.operand_a[0];
        shifted       = 1'b1;
      end
      CMD_BIT: begin
        o.zero        = ~t.operand_a[t.bit_index];
        o.subtract    = 1'b0;
        o.hc_flag     = 1'b1;
        o.writes_back = 1'b0;
      end
      CMD_RES: o.result_byte = t.operand_a & ~(8'h01 << t.bit_index);
      CMD_SET: o.result_byte = t.operand_a | (8'h01 << t.bit_index);
      CMD_DAA: begin
        // decisions look at the unadjusted accumulator
        if (t.subtract) begin
          if (t.hc_flag) adj = adj + DAA_FIX_LO;
          if (t.carry)   adj = adj + DAA_FIX_HI;
          o.result_byte = t.operand_a - adj;
        end else begin
          if (t.hc_flag || t.operand_a[3:0] > DAA_LIMIT_LO) adj = adj + DAA_FIX_LO;
          if (t.carry || t.operand_a > DAA_LIMIT_HI) begin
            adj     = adj + DAA_FIX_HI;
            o.carry = 1'b1;
          end
          o.result_byte = t.operand_a + adj;
        end
        o.zero    = (o.result_byte == 8'h00);
        o.hc_flag = 1'b0;
      end
      CMD_CPL: begin
        o.result_byte = ~t.operand_a;
        o.subtract    = 1'b1;
        o.hc_flag     = 1'b1;
      end
      CMD_SCF, CMD_CCF: begin
        o.subtract    = 1'b0;
        o.hc_flag     = 1'b0;
        o.carry       = (t.command == CMD_SCF) ? 1'b1 : ~t.carry;
        o.writes_back = 1'b0;
      end
      CMD_ADD16: begin
        sum_w  = {1'b0, t.word_a} + {1'b0, t.word_b};
        sum_lo = {1'b0, t.word_a[11:0]} + {1'b0, t.word_b[11:0]};
        o.result_byte = 8'h00;
        o.result_word = sum_w[15:0];
        o.subtract    = 1'b0;
        o.hc_flag     = sum_lo[12];
        o.carry       = sum_w[16];
      end
      default: o.writes_back = 1'b0;
    endcase
    if (shifted) begin
      // accumulator rotates always clear zero
      o.zero     = (t.command >= CMD_RLCA) ? 1'b0 : (o.result_byte == 8'h00);
      o.subtract = 1'b0;
      o.hc_flag  = 1'b0;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [4:0] cmd, int unsigned want,
                                 int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t cmd %0d %s: expected %0h got %0h", $time, cmd, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    ebalu_in_t        txn;
    ebalu_out_t       seen;
    alu_expectation_t exp_item;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        txn = {in_command, in_operand_a, in_operand_b, in_bit_index, in_word_a,
               in_word_b, in_zero_in, in_subtract_in, in_half_carry_in, in_carry_in};
        exp_item.cause   = txn;
        exp_item.outcome = alu_predict(txn);
        pending_outcomes.push_back(exp_item);
      end
      if (out_valid && !out_stall) begin
        seen = {out_result_byte, out_result_word, out_writes_back, out_zero_out,
                out_subtract_out, out_half_carry_out, out_carry_out};
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with nothing pending", 5'd0, 32'd0, 32'(seen));
        end else begin
          exp_item = pending_outcomes.pop_front();
          if (seen.result_byte !== exp_item.outcome.result_byte)
            report_mismatch("result_byte", exp_item.cause.command,
                            32'(exp_item.outcome.result_byte), 32'(seen.result_byte));
          if (seen.result_word !== exp_item.outcome.result_word)
            report_mismatch("result_word", exp_item.cause.command,
                            32'(exp_item.outcome.result_word), 32'(seen.result_word));
          if (seen.writes_back !== exp_item.outcome.writes_back)
            report_mismatch("writes_back", exp_item.cause.command,
                            32'(exp_item.outcome.writes_back), 32'(seen.writes_back));
          if (seen.zero !== exp_item.outcome.zero)
            report_mismatch("zero", exp_item.cause.command,
                            32'(exp_item.outcome.zero), 32'(seen.zero));
          if (seen.subtract !== exp_item.outcome.subtract)
            report_mismatch("subtract", exp_item.cause.command,
                            32'(exp_item.outcome.subtract), 32'(seen.subtract));
          if (seen.hc_flag !== exp_item.outcome.hc_flag)
            report_mismatch("hc_flag", exp_item.cause.command,
                            32'(exp_item.outcome.hc_flag), 32'(seen.hc_flag));
          if (seen.carry !== exp_item.outcome.carry)
            report_mismatch("carry", exp_item.cause.command,
                            32'(exp_item.outcome.carry), 32'(seen.carry));
        end
      end
      awaited_count <= pending_outcomes.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// top of the alu testbench: clock, reset, stimulus, result-side stalls and verdict
`timescale 1ns / 1ps
module tb_top;
  import ebalu_pkg::*;

  // the two command codes the block does not define
  localparam logic [4:0] CMD_SPARE_LO = 5'd30;
  localparam logic [4:0] CMD_SPARE_HI = 5'd31;

  localparam int RANDOM_TXNS = 1800;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [4:0]  in_command       = CMD_ADD;
  logic [7:0]  in_operand_a     = 8'h00;
  logic [7:0]  in_operand_b     = 8'h00;
  logic [2:0]  in_bit_index     = 3'd0;
  logic [15:0] in_word_a        = 16'h0000;
  logic [15:0] in_word_b        = 16'h0000;
  logic        in_zero_in       = 1'b0;
  logic        in_subtract_in   = 1'b0;
  logic        in_half_carry_in = 1'b0;
  logic        in_carry_in      = 1'b0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [7:0]  out_result_byte;
  logic [15:0] out_result_word;
  logic        out_writes_back;
  logic        out_zero_out;
  logic        out_subtract_out;
  logic        out_half_carry_out;
  logic        out_carry_out;

  int unsigned mismatch_count;
  int unsigned awaited_count;

  // percentage of cycles in which each side holds off; zeroed for one long stretch
  int idle_pct = 29;

  eight_bit_alu_with_flags DUT (.*);

  alu_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver side: stall at random, never looking at out_valid
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < idle_pct);
  end

  // operand values with a bias toward the edges of the byte range
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners [8];
    corners = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h7F, 8'h99, 8'h9A};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_word();
    logic [15:0] corners [6];
    corners = '{16'h0000, 16'hFFFF, 16'h0FFF, 16'hF000, 16'h8000, 16'h0001};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 5)];
    return 16'($urandom_range(0, 65535));
  endfunction

  // present one transaction and hold it until the block takes it;
  // flags are packed as zero, subtract, half carry, carry
  task automatic send_txn(logic [4:0] cmd, logic [7:0] a, logic [7:0] b,
                          logic [2:0] idx, logic [15:0] wa, logic [15:0] wb,
                          logic [3:0] flags);
    // random gap before the transaction, geometric length
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_operand_a     <= a;
    in_operand_b     <= b;
    in_bit_index     <= idx;
    in_word_a        <= wa;
    in_word_b        <= wb;
    in_zero_in       <= flags[3];
    in_subtract_in   <= flags[2];
    in_half_carry_in <= flags[1];
    in_carry_in      <= flags[0];
    // in_stall is read before the edge's own updates land, so this is the
    // value the block saw when it took the transaction
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every command at least once, chosen to hit edge values and flag corners
    send_txn(CMD_ADD,   8'hFF, 8'h01, 3'd0, 16'h0000, 16'h0000, 4'b0000); // wraps to zero
    send_txn(CMD_ADC,   8'h0F, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0001); // half carry from carry in
    send_txn(CMD_ADC,   8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0001); // carry from carry in
    send_txn(CMD_SUB,   8'h00, 8'hFF, 3'd0, 16'h0000, 16'h0000, 4'b0000);
    send_txn(CMD_SBC,   8'h10, 8'h0F, 3'd0, 16'h0000, 16'h0000, 4'b0001); // half borrow with carry in
    send_txn(CMD_SBC,   8'h00, 8'hFF, 3'd0, 16'h0000, 16'h0000, 4'b0001);
    send_txn(CMD_AND,   8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b1111);
    send_txn(CMD_XOR,   8'hA5, 8'hA5, 3'd0, 16'h0000, 16'h0000, 4'b0000); // xor to zero
    send_txn(CMD_OR,    8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0111);
    send_txn(CMD_CP,    8'h42, 8'h42, 3'd0, 16'h0000, 16'h0000, 4'b0000); // compare, no write back
    send_txn(CMD_INC,   8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000); // zero on wrap
    send_txn(CMD_DEC,   8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0001); // carry untouched
    send_txn(CMD_RLC,   8'h80, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
    send_txn(CMD_RL,    8'h80, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
    send_txn(CMD_RRC,   8'h01, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b1110);
    send_txn(CMD_RR,    8'h01, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0001);
    send_txn(CMD_SLA,   8'h80, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
    send_txn(CMD_SRA,   8'h81, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
    send_txn(CMD_SWAP,  8'hF0, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0001);
    send_txn(CMD_SRL,   8'h01, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
    send_txn(CMD_BIT,   8'h80, 8'h00, 3'd7, 16'h0000, 16'h0000, 4'b0001); // bit test set
    send_txn(CMD_BIT,   8'h7F, 8'h00, 3'd7, 16'h0000, 16'h0000, 4'b0000); // bit test clear
    send_txn(CMD_RES,   8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b1010);
    send_txn(CMD_SET,   8'h00, 8'h00, 3'd7, 16'h0000, 16'h0000, 4'b0101);
    send_txn(CMD_DAA,   8'h9A, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000); // add side, sets carry
    send_txn(CMD_DAA,   8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0001); // add side, carry kept
    send_txn(CMD_DAA,   8'h66, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0111); // subtract side
    send_txn(CMD_CPL,   8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
    send_txn(CMD_SCF,   8'h5A, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b1110);
    send_txn(CMD_CCF,   8'hA5, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0001);
    send_txn(CMD_RLCA,  8'h80, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b1000);
    send_txn(CMD_RLA,   8'h80, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000); // zero result, zero flag low
    send_txn(CMD_RRCA,  8'h01, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b0000);
    send_txn(CMD_RRA,   8'h01, 8'h00, 3'd0, 16'h0000, 16'h0000, 4'b1000);
    send_txn(CMD_ADD16, 8'h33, 8'h00, 3'd0, 16'hFFFF, 16'h0001, 4'b1000); // zero flag passes
    send_txn(CMD_ADD16, 8'h00, 8'h00, 3'd0, 16'h0FFF, 16'h0001, 4'b0110); // carry out of bit 11
    send_txn(CMD_SPARE_LO, 8'hC3, 8'h00, 3'd0, 16'h1234, 16'h0000, 4'b1111);
    send_txn(CMD_SPARE_HI, 8'h3C, 8'hFF, 3'd7, 16'hFFFF, 16'hFFFF, 4'b0000);

    // random: every code, operands leaning on the corners now and then;
    // one stretch runs with neither side idling to show back-to-back flow
    for (int i = 0; i < RANDOM_TXNS; i++) begin
      idle_pct = (i >= 700 && i < 1000) ? 0 : 29;
      send_txn(5'($urandom_range(CMD_ADD, CMD_SPARE_HI)), pick_byte(), pick_byte(),
               3'($urandom_range(0, 7)), pick_word(), pick_word(),
               4'($urandom_range(0, 15)));
    end
    in_valid <= 1'b0;

    // one edge so the checker's count reflects the last transaction
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/ebalu_pkg.sv
sv/ebalu_core.sv
sv/eight_bit_alu_with_flags.sv
dv/alu_checker.sv
dv/tb_top.sv
